// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ttce_pkg.sv =====
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared constants, codes and types of the text terminal cell engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttce_pkg;

    localparam int MAX_COLUMNS       = 128;
    localparam int MAX_VISIBLE_ROWS  = 32;
    localparam int SCROLLBACK_FACTOR = 8;
    localparam int STORE_ROWS        = MAX_VISIBLE_ROWS * SCROLLBACK_FACTOR;
    localparam int STORE_CELLS       = MAX_COLUMNS * STORE_ROWS;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(STORE_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int VIS_W  = 6;
    localparam int CAP_W  = ROW_W + 1;

    localparam int TAB_SPACES = 4;
    localparam logic [ROW_W-1:0] VIEW_MAX = ROW_W'(STORE_ROWS - MAX_VISIBLE_ROWS);

    // special bytes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BLANK = 8'd32;

    localparam logic [3:0]  RESET_FORE  = 4'd7;
    localparam logic [3:0]  RESET_BACK  = 4'd0;
    localparam logic [15:0] RESET_BLANK = {RESET_BACK, RESET_FORE, CH_BLANK};

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_MOVE  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_PGUP  = 3'd3,
        OP_PGDN  = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        REG_COLUMNS = 2'd0,
        REG_VISIBLE = 2'd1,
        REG_FORE    = 2'd2,
        REG_BACK    = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        K_PLAIN, K_TAB, K_NL, K_CR, K_BS,
        K_MOVE, K_CLEAR, K_PGUP, K_PGDN, K_READ, K_NOP
    } t_kind;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_PUT, S_SCROLL, S_BLANK, S_CLEAR, S_READ, S_DONE
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       code;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic [7:0]       columns;
        logic [VIS_W-1:0] visible_rows;
        logic [3:0]       fore;
        logic [3:0]       back;
    } t_cfg;

    // back end status seen by the front end
    typedef struct packed {
        logic init;
    } t_status;

endpackage

// ===== rtl/ttce_if.sv =====
// ----------------------------------------------------------------------------
// ttce_if
// Handshake channels of the engine: command in, result out, register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttce_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [7:0] row;
    modport source (output valid, operation, char_code, column, row, input ready);
    modport sink   (input valid, operation, char_code, column, row, output ready);
endinterface

interface ttce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [3:0] cell_fore;
    logic [3:0] cell_back;
    logic [6:0] cursor_column;
    logic [7:0] cursor_row;
    logic [7:0] view_offset;
    modport source (output valid, cell_char, cell_fore, cell_back, cursor_column,
                    cursor_row, view_offset, input ready);
    modport sink   (input valid, cell_char, cell_fore, cell_back, cursor_column,
                    cursor_row, view_offset, output ready);
endinterface

interface ttce_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ttce_front.sv =====
// ----------------------------------------------------------------------------
// ttce_front
// Accepts commands, decodes them into work kinds and queues them (2 deep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttce_front
    import ttce_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttce_in_if.sink      i_in,
    input  t_status      i_status,
    input  logic         i_cmd_pop,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cmd_dec;
    logic       push;

    // classify the incoming transfer
    always_comb begin
        cmd_dec.code   = i_in.char_code;
        cmd_dec.column = i_in.column;
        cmd_dec.row    = i_in.row;
        unique case (i_in.operation)
            OP_PUT: begin
                case (i_in.char_code)
                    CH_LF:   cmd_dec.kind = K_NL;
                    CH_CR:   cmd_dec.kind = K_CR;
                    CH_TAB:  cmd_dec.kind = K_TAB;
                    CH_BS:   cmd_dec.kind = K_BS;
                    default: cmd_dec.kind = K_PLAIN;
                endcase
            end
            OP_MOVE:  cmd_dec.kind = K_MOVE;
            OP_CLEAR: cmd_dec.kind = K_CLEAR;
            OP_PGUP:  cmd_dec.kind = K_PGUP;
            OP_PGDN:  cmd_dec.kind = K_PGDN;
            OP_READ:  cmd_dec.kind = K_READ;
            default:  cmd_dec.kind = K_NOP;
        endcase
    end

    assign i_in.ready  = (r_cnt != 2'd2) && !i_status.init;
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_dec;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule

// ===== rtl/ttce_back.sv =====
// ----------------------------------------------------------------------------
// ttce_back
// Executes queued commands: cursor, view, cell memory, scroll and clear sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttce_back
    import ttce_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_cmd_valid,
    input  t_cmd         i_cmd,
    output logic         o_cmd_pop,
    output t_status      o_status,
    ttce_out_if.source   o_out
);

    logic [15:0] mem [STORE_CELLS];

    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [ROW_W-1:0]    r_view, n_view;
    logic [7:0]          r_code, n_code;
    logic [1:0]          r_reps, n_reps;
    logic                r_resume, n_resume;
    logic                r_is_read, n_is_read;
    logic [ROW_W-1:0]    r_sr, n_sr;
    logic [COL_W-1:0]    r_sc, n_sc;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic                r_wv, n_wv;
    logic [ADDR_W-1:0]   r_wa, n_wa;
    logic [15:0]         r_wd, n_wd;
    logic                r_wcopy, n_wcopy;
    logic [15:0]         r_rd;

    logic                r_out_valid;
    logic [15:0]         r_out_cell;
    logic [COL_W-1:0]    r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic [ROW_W-1:0]    r_out_view;

    logic [7:0]          cols;
    logic [COL_W-1:0]    cols_m1;
    logic [VIS_W-1:0]    page;
    logic [CAP_W-1:0]    cap;
    logic [ROW_W-1:0]    cap_m1;
    logic [CAP_W-1:0]    top;
    logic [15:0]         blank;
    logic [COL_W-1:0]    tcol;
    logic [ROW_W-1:0]    trow;
    logic [7:0]          col_inc;
    logic [CAP_W-1:0]    row_inc;
    logic [ROW_W-1:0]    pg_d;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [15:0]         mem_wdata;
    logic                out_free;
    logic                push;

    // effective geometry
    always_comb begin
        if (i_cfg.columns == 8'd0) begin
            cols = 8'd1;
        end else if (i_cfg.columns > 8'(MAX_COLUMNS)) begin
            cols = 8'(MAX_COLUMNS);
        end else begin
            cols = i_cfg.columns;
        end
        if (i_cfg.visible_rows == '0) begin
            page = VIS_W'(1);
        end else if (i_cfg.visible_rows > VIS_W'(MAX_VISIBLE_ROWS)) begin
            page = VIS_W'(MAX_VISIBLE_ROWS);
        end else begin
            page = i_cfg.visible_rows;
        end
    end

    assign cols_m1 = COL_W'(cols - 8'd1);
    assign cap     = CAP_W'(page) * CAP_W'(SCROLLBACK_FACTOR);
    assign cap_m1  = ROW_W'(cap - CAP_W'(1));
    assign top     = cap - CAP_W'(page);
    assign blank   = {i_cfg.back, i_cfg.fore, CH_BLANK};

    // clamped targets of move and read
    assign tcol = (8'(i_cmd.column) >= cols) ? cols_m1 : i_cmd.column;
    assign trow = (CAP_W'(i_cmd.row) >= cap) ? cap_m1 : i_cmd.row;

    assign col_inc  = 8'(r_col) + 8'd1;
    assign row_inc  = CAP_W'(r_row) + CAP_W'(1);
    assign pg_d     = ROW_W'(top - CAP_W'(r_view));
    assign out_free = !r_out_valid || o_out.ready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_view    = r_view;
        n_code    = r_code;
        n_reps    = r_reps;
        n_resume  = r_resume;
        n_is_read = r_is_read;
        n_sr      = r_sr;
        n_sc      = r_sc;
        n_clr     = r_clr;
        n_wv      = 1'b0;
        n_wa      = r_wa;
        n_wd      = r_wd;
        n_wcopy   = 1'b0;
        o_cmd_pop = 1'b0;
        push      = 1'b0;
        mem_raddr = {r_sr, r_sc};

        unique case (r_state)
            // reset fill of the whole store
            S_INIT: begin
                n_wv  = 1'b1;
                n_wa  = r_clr;
                n_wd  = RESET_BLANK;
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_is_read = 1'b0;
                    n_reps    = 2'd0;
                    n_state   = S_DONE;
                    unique case (i_cmd.kind)
                        K_PLAIN: begin
                            n_code  = i_cmd.code;
                            n_state = S_PUT;
                        end
                        K_TAB: begin
                            n_code  = CH_BLANK;
                            n_reps  = 2'(TAB_SPACES - 1);
                            n_state = S_PUT;
                        end
                        K_NL: begin
                            n_col = '0;
                            if (row_inc >= cap) begin
                                n_row    = cap_m1;
                                n_sr     = ROW_W'(1);
                                n_sc     = '0;
                                n_resume = 1'b0;
                                n_state  = S_SCROLL;
                            end else begin
                                n_row = ROW_W'(row_inc);
                            end
                        end
                        K_CR: n_col = '0;
                        K_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - COL_W'(1);
                            end
                        end
                        K_MOVE: begin
                            n_col = tcol;
                            n_row = trow;
                        end
                        K_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_view  = '0;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        K_PGUP: begin
                            n_view = (r_view > ROW_W'(page)) ? r_view - ROW_W'(page) : '0;
                        end
                        K_PGDN: begin
                            if (CAP_W'(r_view) < top) begin
                                n_view = r_view +
                                         ((ROW_W'(page) < pg_d) ? ROW_W'(page) : pg_d);
                            end
                        end
                        K_READ: begin
                            n_sr      = trow;
                            n_sc      = tcol;
                            n_is_read = 1'b1;
                            n_state   = S_READ;
                        end
                        default: ;
                    endcase
                end
            end

            // one plain cell write; scroll before or after as needed
            S_PUT: begin
                if (CAP_W'(r_row) >= cap) begin
                    n_row    = cap_m1;
                    n_sr     = ROW_W'(1);
                    n_sc     = '0;
                    n_resume = 1'b1;
                    n_state  = S_SCROLL;
                end else begin
                    n_wv = 1'b1;
                    n_wa = {r_row, r_col};
                    n_wd = {i_cfg.back, i_cfg.fore, r_code};
                    if (col_inc >= cols) begin
                        n_col = '0;
                        if (row_inc >= cap) begin
                            n_row    = cap_m1;
                            n_sr     = ROW_W'(1);
                            n_sc     = '0;
                            n_resume = 1'b0;
                            n_state  = S_SCROLL;
                        end else begin
                            n_row = ROW_W'(row_inc);
                        end
                    end else begin
                        n_col = COL_W'(col_inc);
                    end
                    if (n_state == S_PUT) begin
                        if (r_reps != 2'd0) begin
                            n_reps = r_reps - 2'd1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end

            // copy row r to row r-1, one cell a cycle; each write uses the registered read data
            S_SCROLL: begin
                n_wv    = 1'b1;
                n_wa    = {r_sr - ROW_W'(1), r_sc};
                n_wcopy = 1'b1;
                if (r_sc == cols_m1) begin
                    n_sc = '0;
                    if (r_sr == cap_m1) begin
                        n_state = S_BLANK;
                    end else begin
                        n_sr = r_sr + ROW_W'(1);
                    end
                end else begin
                    n_sc = r_sc + COL_W'(1);
                end
            end

            // blank the last row in use
            S_BLANK: begin
                n_wv = 1'b1;
                n_wa = {cap_m1, r_sc};
                n_wd = blank;
                n_sc = r_sc + COL_W'(1);
                if (r_sc == cols_m1) begin
                    if (r_resume) begin
                        n_state = S_PUT;
                    end else if (r_reps != 2'd0) begin
                        n_reps  = r_reps - 2'd1;
                        n_state = S_PUT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_CLEAR: begin
                n_wv  = 1'b1;
                n_wa  = r_clr;
                n_wd  = blank;
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_DONE;
                end
            end

            // read address issued here, data lands in r_rd
            S_READ: n_state = S_DONE;

            S_DONE: begin
                push    = 1'b1;
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_view  <= '0;
            r_clr   <= '0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_view  <= n_view;
            r_clr   <= n_clr;
            r_wv    <= n_wv;
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_reps    <= n_reps;
        r_resume  <= n_resume;
        r_is_read <= n_is_read;
        r_sr      <= n_sr;
        r_sc      <= n_sc;
        r_wa      <= n_wa;
        r_wd      <= n_wd;
        r_wcopy   <= n_wcopy;
    end

    // cell memory, one write and one registered read per cycle
    assign mem_wdata = r_wcopy ? r_rd : r_wd;

    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            mem[r_wa] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_cell <= r_is_read ? r_rd : 16'd0;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_view <= r_view;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.cell_char     = r_out_cell[7:0];
    assign o_out.cell_fore     = r_out_cell[11:8];
    assign o_out.cell_back     = r_out_cell[15:12];
    assign o_out.cursor_column = r_out_col;
    assign o_out.cursor_row    = r_out_row;
    assign o_out.view_offset   = r_out_view;

    assign o_status.init = (r_state == S_INIT);

endmodule

// ===== rtl/text_terminal_cell_engine.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_engine
// Character-cell terminal store with scrollback, cursor and view paging.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command per transfer (operation, char_code, column, row);
//   o_out returns exactly one result per command, in order. i_cfg writes the
//   columns, visible_rows, fore_color and back_color registers (index 0..3);
//   write them only while no command is outstanding.
//   A front end decodes commands into a two-entry queue; the back end runs
//   them against a 32768 x 16 cell memory with one write and one read port.
//   The back end pops a command only from idle and only while the result
//   register is free, and returns to idle after pushing that result, so it
//   works on one command at a time; the put, read, scroll, blank and clear
//   states run between the pop and the push.
//   A scroll sweeps columns x capacity cells (capacity = 8 x visible rows),
//   one cell per cycle on the memory port; clear sweeps all 32768 cells.
//   After reset all 32768 cells are filled with blanks (color 7 on 0),
//   during which i_in.ready stays low; config writes are taken.
//   If o_out is stalled the result waits in its register, the back end stops
//   before the next command and the queue still takes up to two transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_terminal_cell_engine
    import ttce_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttce_in_if.sink      i_in,
    ttce_out_if.source   o_out,
    ttce_cfg_if.sink     i_cfg
);

    t_cfg    r_cfg;
    t_status status;
    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_pop;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns      <= 8'd80;
            r_cfg.visible_rows <= VIS_W'(25);
            r_cfg.fore         <= RESET_FORE;
            r_cfg.back         <= RESET_BACK;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_COLUMNS: r_cfg.columns      <= i_cfg.data;
                REG_VISIBLE: r_cfg.visible_rows <= i_cfg.data[VIS_W-1:0];
                REG_FORE:    r_cfg.fore         <= i_cfg.data[3:0];
                REG_BACK:    r_cfg.back         <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    ttce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_status    (status),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    ttce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_status    (status),
        .o_out       (o_out)
    );

    `ASSERT_IMPL(a_no_accept_in_init, i_clk, i_rst_n, status.init, !i_in.ready)
    `ASSERT_IMPL(a_pop_needs_entry, i_clk, i_rst_n, cmd_pop, cmd_valid && !status.init)
    `ASSERT_IMPL(a_view_bound, i_clk, i_rst_n, o_out.valid, o_out.view_offset <= VIEW_MAX)

endmodule

// ===== verif/text_terminal_cell_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_engine_tb
// Self-checking bench for the terminal cell engine. A cycle-free predictor
// mirrors the cell store, cursor and view offset. Every command transfer
// pushes one expected result, and each result transfer is checked against it.
// Directed tests cover the special bytes, clamping, wrap, scroll, clear,
// paging, unused codes and a cursor left beyond shrunk limits. Random phases
// follow, most of them at small geometries so that scroll sweeps stay short.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine_tb;
    import ttce_pkg::*;

    localparam int          WATCHDOG_LIMIT = 200000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [2:0]  OP_SPARE_6     = 3'd6;
    localparam logic [2:0]  OP_SPARE_7     = 3'd7;

    typedef struct {
        logic [7:0] ch;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [6:0] col;
        logic [7:0] row;
        logic [7:0] view;
    } cell_result_t;

    logic i_clk;
    logic i_rst_n;

    ttce_in_if  in_if();
    ttce_out_if out_if();
    ttce_cfg_if cfg_if();

    text_terminal_cell_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // terminal shadow state
    logic [15:0]  shadow_cells [STORE_CELLS];
    int           sh_col, sh_row, sh_view;
    logic [7:0]   sh_columns;
    logic [5:0]   sh_visible;
    logic [3:0]   sh_fore, sh_back;

    cell_result_t pending_results [$];
    int           mismatch_count;
    int           cmds_sent, results_seen, scroll_count, clear_count;
    int           burst_left;

    function automatic int term_cols();
        if (sh_columns == 0) return 1;
        if (sh_columns > MAX_COLUMNS) return MAX_COLUMNS;
        return sh_columns;
    endfunction

    function automatic int term_page();
        if (sh_visible == 0) return 1;
        if (sh_visible > MAX_VISIBLE_ROWS) return MAX_VISIBLE_ROWS;
        return sh_visible;
    endfunction

    function automatic int term_cap();
        return term_page() * SCROLLBACK_FACTOR;
    endfunction

    function automatic logic [15:0] colored(logic [7:0] code);
        return {sh_back, sh_fore, code};
    endfunction

    function automatic void shadow_reset();
        sh_columns = 8'd80;
        sh_visible = 6'd25;
        sh_fore    = RESET_FORE;
        sh_back    = RESET_BACK;
        for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = RESET_BLANK;
        sh_col  = 0;
        sh_row  = 0;
        sh_view = 0;
    endfunction

    // shift all rows up one once the cursor runs past the last row
    function automatic void shadow_scroll_check();
        int cap;
        int cols;
        cap  = term_cap();
        cols = term_cols();
        if (sh_row < cap) return;
        scroll_count++;
        sh_row = cap - 1;
        for (int r = 1; r < cap; r++)
            for (int c = 0; c < cols; c++)
                shadow_cells[(r-1)*MAX_COLUMNS + c] = shadow_cells[r*MAX_COLUMNS + c];
        for (int c = 0; c < cols; c++)
            shadow_cells[(cap-1)*MAX_COLUMNS + c] = colored(CH_BLANK);
    endfunction

    function automatic void shadow_put_plain(logic [7:0] code);
        if (sh_row >= term_cap()) shadow_scroll_check();
        if (sh_row < STORE_ROWS && sh_col < MAX_COLUMNS)
            shadow_cells[sh_row*MAX_COLUMNS + sh_col] = colored(code);
        sh_col++;
        if (sh_col >= term_cols()) begin
            sh_col = 0;
            sh_row++;
        end
        shadow_scroll_check();
    endfunction

    function automatic cell_result_t shadow_apply(logic [2:0] op, logic [7:0] code,
                                                  logic [6:0] col, logic [7:0] row);
        cell_result_t res;
        int tcol, trow, top, gap;
        logic [15:0] v;
        tcol = col;
        trow = row;
        res.ch = '0;
        res.fg = '0;
        res.bg = '0;
        if (tcol >= term_cols()) tcol = term_cols() - 1;
        if (trow >= term_cap()) trow = term_cap() - 1;
        case (op)
            OP_PUT: begin
                case (code)
                    CH_LF: begin
                        sh_col = 0;
                        sh_row++;
                        shadow_scroll_check();
                    end
                    CH_CR: sh_col = 0;
                    CH_TAB: for (int i = 0; i < TAB_SPACES; i++) shadow_put_plain(CH_BLANK);
                    CH_BS: if (sh_col > 0) sh_col--;
                    default: shadow_put_plain(code);
                endcase
            end
            OP_MOVE: begin
                sh_col = tcol;
                sh_row = trow;
            end
            OP_CLEAR: begin
                clear_count++;
                for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = colored(CH_BLANK);
                sh_col  = 0;
                sh_row  = 0;
                sh_view = 0;
            end
            OP_PGUP: sh_view = (sh_view > term_page()) ? sh_view - term_page() : 0;
            OP_PGDN: begin
                top = (term_cap() > term_page()) ? term_cap() - term_page() : 0;
                if (sh_view < top) begin
                    gap = top - sh_view;
                    sh_view += (term_page() < gap) ? term_page() : gap;
                end
            end
            OP_READ: begin
                v = shadow_cells[trow*MAX_COLUMNS + tcol];
                res.ch = v[7:0];
                res.fg = v[11:8];
                res.bg = v[15:12];
            end
            default: ;
        endcase
        res.col  = sh_col[6:0];
        res.row  = sh_row[7:0];
        res.view = sh_view[7:0];
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        mismatch_count++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        cell_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.cell_char !== want.ch) report("cell_char", out_if.cell_char, want.ch);
                if (out_if.cell_fore !== want.fg) report("cell_fore", out_if.cell_fore, want.fg);
                if (out_if.cell_back !== want.bg) report("cell_back", out_if.cell_back, want.bg);
                if (out_if.cursor_column !== want.col)
                    report("cursor_column", out_if.cursor_column, want.col);
                if (out_if.cursor_row !== want.row)
                    report("cursor_row", out_if.cursor_row, want.row);
                if (out_if.view_offset !== want.view)
                    report("view_offset", out_if.view_offset, want.view);
            end
        end
    end

    // receiver stall pattern: free flow, random drops, or periodic drops
    int stall_mode, stall_left, stall_tick;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= (stall_tick % 3 != 0);
        endcase
    end

    // watchdog on cycles without any transfer
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one command transfer; enters and leaves at a falling edge
    task automatic send_cmd(logic [2:0] op, logic [7:0] code, logic [6:0] col,
                            logic [7:0] row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.char_code <= code;
        in_if.column    <= col;
        in_if.row       <= row;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results.push_back(shadow_apply(op, code, col, row));
        cmds_sent++;
        @(negedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [7:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_COLUMNS: sh_columns = data;
            REG_VISIBLE: sh_visible = data[5:0];
            REG_FORE:    sh_fore    = data[3:0];
            default:     sh_back    = data[3:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [7:0] cols, logic [7:0] rows, logic [3:0] fg,
                              logic [3:0] bg);
        drain();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_VISIBLE, rows);
        write_reg(REG_FORE, {4'h0, fg});
        write_reg(REG_BACK, {4'($urandom_range(0, 15)), bg});
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic put(logic [7:0] code);
        send_cmd(OP_PUT, code, 7'($urandom), 8'($urandom));
    endtask

    task automatic read_cell(logic [6:0] col, logic [7:0] row);
        send_cmd(OP_READ, 8'($urandom), col, row);
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        read_cell(7'd0, 8'd0);
        read_cell(7'd127, 8'd255);
        send_cmd(OP_PGUP, 8'd0, 7'd0, 8'd0);
        send_cmd(OP_PGDN, 8'd0, 7'd0, 8'd0);
        send_cmd(OP_SPARE_6, 8'hFF, 7'h7F, 8'hFF);
        send_cmd(OP_SPARE_7, 8'h00, 7'h00, 8'h00);
    endtask

    task automatic test_special_bytes();
        put(8'h41);
        put(8'hFF);
        put(8'h00);
        put(CH_TAB);
        put(CH_BS);
        put(CH_CR);
        put(CH_BS);
        put(CH_LF);
        read_cell(7'd1, 8'd0);
        read_cell(7'd2, 8'd0);
    endtask

    task automatic test_wrap_and_scroll();
        set_config(8'd4, 8'd2, 4'd15, 4'd15);
        send_cmd(OP_MOVE, 8'd0, 7'd127, 8'd255);
        put(8'h5A);
        put(8'h30);
        put(CH_TAB);
        send_cmd(OP_MOVE, 8'd0, 7'd0, 8'd15);
        put(CH_LF);
        read_cell(7'd0, 8'd15);
    endtask

    // cursor left past shrunk limits, out-of-range register values
    task automatic test_beyond_limits();
        set_config(8'd255, 8'd63, 4'd1, 4'd2);
        send_cmd(OP_MOVE, 8'd0, 7'd127, 8'd255);
        put(8'h7E);
        read_cell(7'd127, 8'd254);
        send_cmd(OP_MOVE, 8'd0, 7'd120, 8'd200);
        set_config(8'd0, 8'd0, 4'd3, 4'd4);
        put(8'h21);
        read_cell(7'd0, 8'd7);
        set_config(8'd8, 8'd1, 4'd5, 4'd6);
        send_cmd(OP_MOVE, 8'd0, 7'd7, 8'd7);
        set_config(8'd2, 8'd1, 4'd5, 4'd6);
        put(8'h22);
        put(CH_LF);
    endtask

    task automatic test_paging();
        set_config(8'd8, 8'd32, 4'd9, 4'd10);
        repeat (8) send_cmd(OP_PGDN, 8'd0, 7'd0, 8'd0);
        set_config(8'd8, 8'd4, 4'd9, 4'd10);
        send_cmd(OP_PGDN, 8'd0, 7'd0, 8'd0);
        send_cmd(OP_PGUP, 8'd0, 7'd0, 8'd0);
    endtask

    task automatic test_clear();
        set_config(8'd16, 8'd2, 4'd3, 4'd12);
        send_cmd(OP_CLEAR, 8'd0, 7'd0, 8'd0);
        read_cell(7'd127, 8'd255);
    endtask

    // ------------------------------------------------------------------
    // random phases
    // ------------------------------------------------------------------
    task automatic random_op();
        int pick;
        int clears_left;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            put(8'($urandom_range(33, 126)));
        end else if (pick < 55) begin
            case ($urandom_range(0, 3))
                0: put(CH_LF);
                1: put(CH_CR);
                2: put(CH_TAB);
                default: put(CH_BS);
            endcase
        end else if (pick < 62) begin
            put(8'($urandom));
        end else if (pick < 72) begin
            send_cmd(OP_MOVE, 8'($urandom), 7'($urandom), 8'($urandom));
        end else if (pick < 86) begin
            read_cell(7'($urandom), 8'($urandom));
        end else if (pick < 92) begin
            send_cmd(OP_PGUP, 8'($urandom), 7'($urandom), 8'($urandom));
        end else if (pick < 98) begin
            send_cmd(OP_PGDN, 8'($urandom), 7'($urandom), 8'($urandom));
        end else begin
            send_cmd($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                     8'($urandom), 7'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random(int phases, int per_phase);
        logic [7:0] cols, rows;
        for (int p = 0; p < phases; p++) begin
            // keep columns x capacity small so scroll sweeps stay short
            case ($urandom_range(0, 3))
                0: begin cols = 8'd255; rows = 8'd1; end
                1: begin cols = 8'($urandom_range(0, 3)); rows = 8'd63; end
                default: begin
                    cols = 8'($urandom_range(1, 16));
                    rows = 8'($urandom_range(0, 3));
                end
            endcase
            set_config(cols, rows, 4'($urandom), 4'($urandom));
            for (int i = 0; i < per_phase; i++) begin
                // a text run ending in a newline one time in three, else a scattered op
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 20)) put(8'($urandom_range(32, 126)));
                    put(CH_LF);
                end else begin
                    random_op();
                end
            end
        end
        set_config(8'd40, 8'd8, 4'($urandom), 4'($urandom));
        send_cmd(OP_CLEAR, 8'd0, 7'd0, 8'd0);
        repeat (40) random_op();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_PUT;
        in_if.char_code = '0;
        in_if.column    = '0;
        in_if.row       = '0;
        out_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_COLUMNS;
        cfg_if.data     = '0;
        mismatch_count  = 0;
        burst_left      = 0;
        shadow_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_special_bytes();
        test_wrap_and_scroll();
        test_beyond_limits();
        test_paging();
        test_clear();
        test_random(11, 32);

        drain();
        if (pending_results.size() != 0)
            report("results left over", pending_results.size(), 0);
        $display("covered %0d commands, %0d results, %0d scrolls, %0d clears",
                 cmds_sent, results_seen, scroll_count, clear_count);
        $display("with random geometry, colors, paging and stalls on both sides");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
